// ===== sv/scsg_pkg.sv =====
package scsg_pkg;

    localparam int unsigned MAX_LEVEL = 8;

    localparam int unsigned LVL_W  = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned TP_W   = 4;
    localparam int unsigned IDX_W  = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
    localparam int unsigned DEP_W  = $clog2(MAX_LEVEL + 1);

    localparam logic CFG_LEVEL = 1'b0;
    localparam logic CFG_SIZE  = 1'b1;

    localparam logic [DATA_W-1:0] SIZE_RESET = 32'd4194304;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] phase;
    } t_frame;

    typedef struct packed {
        logic signed [2:0] mx;
        logic signed [2:0] my;
    } t_move;

    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_stat;

    function automatic logic [1:0] child_kind(input logic [1:0] kind, input logic [1:0] c);
        logic [1:0] k;
        begin
            case (kind)
                2'd0: k = (c == 2'd2) ? 2'd3 : ((c == 2'd1) ? 2'd1 : 2'd0);
                2'd1: k = (c == 2'd2) ? 2'd0 : ((c == 2'd1) ? 2'd2 : 2'd1);
                2'd2: k = (c == 2'd2) ? 2'd1 : ((c == 2'd1) ? 2'd3 : 2'd2);
                default: k = (c == 2'd2) ? 2'd2 : ((c == 2'd1) ? 2'd0 : 2'd3);
            endcase
            return k;
        end
    endfunction

    function automatic t_move inner_move(input logic [1:0] kind, input logic [1:0] c);
        t_move m;
        begin
            case ({kind, c})
                4'b00_00: m = '{ 3'sd1,  3'sd1};
                4'b00_01: m = '{ 3'sd2,  3'sd0};
                4'b00_10: m = '{ 3'sd1, -3'sd1};
                4'b01_00: m = '{-3'sd1,  3'sd1};
                4'b01_01: m = '{ 3'sd0,  3'sd2};
                4'b01_10: m = '{ 3'sd1,  3'sd1};
                4'b10_00: m = '{-3'sd1, -3'sd1};
                4'b10_01: m = '{-3'sd2,  3'sd0};
                4'b10_10: m = '{-3'sd1,  3'sd1};
                4'b11_00: m = '{ 3'sd1, -3'sd1};
                4'b11_01: m = '{ 3'sd0, -3'sd2};
                4'b11_10: m = '{-3'sd1, -3'sd1};
                default:  m = '{ 3'sd0,  3'sd0};
            endcase
            return m;
        end
    endfunction

    function automatic t_move outer_move(input logic [1:0] k);
        t_move m;
        begin
            case (k)
                2'd0: m = '{ 3'sd1,  3'sd1};
                2'd1: m = '{-3'sd1,  3'sd1};
                2'd2: m = '{-3'sd1, -3'sd1};
                default: m = '{ 3'sd1, -3'sd1};
            endcase
            return m;
        end
    endfunction

    function automatic logic [DATA_W-1:0] scale(input logic signed [2:0] m,
                                                 input logic [DATA_W-1:0] u);
        logic [DATA_W-1:0] r;
        begin
            case (m)
                3'sd1:   r = u;
                3'sd2:   r = {u[DATA_W-2:0], 1'b0};
                -3'sd1:  r = DATA_W'(0) - u;
                -3'sd2:  r = DATA_W'(0) - {u[DATA_W-2:0], 1'b0};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [LVL_W-1:0] eff_level(input logic [LVL_W-1:0] lvl);
        return (lvl > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : lvl;
    endfunction

endpackage

// ===== sv/scsg_in_if.sv =====
interface scsg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// ===== sv/scsg_out_if.sv =====
interface scsg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic               is_relative;
    logic               is_last;

    modport source (output valid, output step_x, output step_y, output is_relative,
                    output is_last, input ready);
    modport sink (input valid, input step_x, input step_y, input is_relative,
                  input is_last, output ready);
endinterface

// ===== sv/scsg_ctrl.sv =====
module scsg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  scsg_pkg::t_stat i_stat,
    output scsg_pkg::t_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;
    logic walking;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign walking    = (r_state == S_WALK);

    assign o_cmd.start = accept;
    assign o_cmd.step  = walking && (!i_stat.emit || i_stat.out_free);
    assign o_cmd.load  = walking && i_stat.emit && i_stat.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (o_cmd.load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WALK))
        else $error("accepted transfer did not start a walk");

    a_load_only_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (walking && o_cmd.step))
        else $error("result loaded outside a committed step");

    a_load_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_IDLE))
        else $error("walk did not end after result load");

endmodule

// ===== sv/scsg_dpath.sv =====
module scsg_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [scsg_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                            i_restart,
    input  scsg_pkg::t_cmd                  i_cmd,
    output scsg_pkg::t_stat                 o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic signed [scsg_pkg::DATA_W-1:0] o_step_x,
    output logic signed [scsg_pkg::DATA_W-1:0] o_step_y,
    output logic                            o_is_relative,
    output logic                            o_is_last
);

    localparam int unsigned DW  = scsg_pkg::DATA_W;
    localparam int unsigned LW  = scsg_pkg::LVL_W;
    localparam int unsigned IW  = scsg_pkg::IDX_W;
    localparam int unsigned DPW = scsg_pkg::DEP_W;
    localparam int unsigned TW  = scsg_pkg::TP_W;

    logic [LW-1:0]      r_level;
    logic [DW-1:0]      r_size;
    logic [DW-1:0]      r_unit;
    logic [DPW-1:0]     r_depth;
    logic [TW-1:0]      r_top_phase;
    scsg_pkg::t_frame   r_stack [scsg_pkg::MAX_LEVEL];

    logic               r_out_valid;
    logic [DW-1:0]      r_out_x;
    logic [DW-1:0]      r_out_y;
    logic               r_out_rel;
    logic               r_out_last;

    logic [LW-1:0]      lvl;
    logic [LW-1:0]      cfg_lvl;
    logic [DW-1:0]      cfg_size;
    logic [DW-1:0]      cfg_unit;

    logic [IW-1:0]      top_idx;
    logic [IW-1:0]      push_idx;
    scsg_pkg::t_frame   top_frame;
    logic [1:0]         conn;
    logic [1:0]         k_odd;
    logic [1:0]         k_even;
    logic               push_ok;

    logic [DPW-1:0]     n_depth;
    logic [TW-1:0]      n_top_phase;
    logic               wr_top;
    scsg_pkg::t_frame   wr_top_data;
    logic               wr_push;
    scsg_pkg::t_frame   wr_push_data;
    logic               emit;
    logic               emit_abs;
    logic               emit_last;
    scsg_pkg::t_move    mv;
    logic [DW-1:0]      ex;
    logic [DW-1:0]      ey;

    assign lvl = scsg_pkg::eff_level(r_level);

    // unit length from the settings in force after this write
    assign cfg_lvl  = scsg_pkg::eff_level((i_cfg_index == scsg_pkg::CFG_LEVEL)
                                          ? i_cfg_data[LW-1:0] : r_level);
    assign cfg_size = (i_cfg_index == scsg_pkg::CFG_SIZE) ? i_cfg_data : r_size;
    assign cfg_unit = cfg_size >> ((LW + 1)'(cfg_lvl) + (LW + 1)'(2));

    assign top_idx   = IW'(r_depth - DPW'(1));
    assign push_idx  = IW'(r_depth);
    assign top_frame = r_stack[top_idx];
    assign conn      = top_frame.phase[2:1];
    assign k_odd     = 2'((r_top_phase - TW'(1)) >> 1);
    assign k_even    = 2'((r_top_phase - TW'(2)) >> 1);
    assign push_ok   = ((LW + 2)'(lvl) > ((LW + 2)'(top_idx) + (LW + 2)'(1)))
                       && (r_depth < DPW'(scsg_pkg::MAX_LEVEL));

    always_comb begin
        n_depth      = r_depth;
        n_top_phase  = r_top_phase;
        wr_top       = 1'b0;
        wr_top_data  = '{kind: top_frame.kind, phase: top_frame.phase + 3'd1};
        wr_push      = 1'b0;
        wr_push_data = '{kind: 2'd0, phase: 3'd0};
        emit         = 1'b0;
        emit_abs     = 1'b0;
        emit_last    = 1'b0;
        mv           = '{3'sd0, 3'sd0};
        if (r_depth == '0) begin
            if (r_top_phase == '0) begin
                emit        = 1'b1;
                emit_abs    = 1'b1;
                n_top_phase = TW'(1);
            end else if (r_top_phase[0]) begin
                n_top_phase = r_top_phase + TW'(1);
                if (lvl != '0) begin
                    wr_push      = 1'b1;
                    wr_push_data = '{kind: k_odd, phase: 3'd0};
                    n_depth      = DPW'(1);
                end
            end else begin
                emit_last   = (k_even == 2'd3);
                n_top_phase = emit_last ? '0 : r_top_phase + TW'(1);
                emit        = 1'b1;
                mv          = scsg_pkg::outer_move(k_even);
            end
        end else begin
            if (!top_frame.phase[0]) begin
                wr_top = 1'b1;
                if (push_ok) begin
                    wr_push      = 1'b1;
                    wr_push_data = '{kind: scsg_pkg::child_kind(top_frame.kind, conn),
                                     phase: 3'd0};
                    n_depth      = r_depth + DPW'(1);
                end
            end else if (conn == 2'd3) begin
                n_depth = r_depth - DPW'(1);
            end else begin
                wr_top = 1'b1;
                emit   = 1'b1;
                mv     = scsg_pkg::inner_move(top_frame.kind, conn);
            end
        end
    end

    assign ex = emit_abs ? {r_unit[DW-2:0], 1'b0} : scsg_pkg::scale(mv.mx, r_unit);
    assign ey = emit_abs ? r_unit : scsg_pkg::scale(mv.my, r_unit);

    assign o_stat.emit     = emit;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_size      <= scsg_pkg::SIZE_RESET;
            r_unit      <= scsg_pkg::SIZE_RESET >> 2;
            r_depth     <= '0;
            r_top_phase <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == scsg_pkg::CFG_LEVEL) begin
                r_level <= i_cfg_data[LW-1:0];
            end else begin
                r_size <= i_cfg_data;
            end
            r_unit      <= cfg_unit;
            r_depth     <= '0;
            r_top_phase <= '0;
        end else if (i_cmd.start && i_restart) begin
            r_depth     <= '0;
            r_top_phase <= '0;
        end else if (i_cmd.step) begin
            r_depth     <= n_depth;
            r_top_phase <= n_top_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && wr_top) begin
            r_stack[top_idx] <= wr_top_data;
        end
        if (i_cmd.step && wr_push) begin
            r_stack[push_idx] <= wr_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_x    <= ex;
            r_out_y    <= ey;
            r_out_rel  <= !emit_abs;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_x      = r_out_x;
    assign o_step_y      = r_out_y;
    assign o_is_relative = r_out_rel;
    assign o_is_last     = r_out_last;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DPW'(scsg_pkg::MAX_LEVEL))
        else $error("frame stack overflow");

    a_depth_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) |-> (!r_top_phase[0] && r_top_phase != '0))
        else $error("live frames outside a production slot");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (emit && (!r_out_valid || i_out_ready)))
        else $error("result loaded over a pending transfer");

endmodule

// ===== sv/sierpinski_curve_step_generator.sv =====
// Sierpinski closed-curve vertex generator. Each input transfer yields one output
// transfer: the first vertex of a curve is absolute (is_relative low), every later one is
// a step of up to two unit lengths per axis, and is_last marks the closing vertex after
// which the curve starts over. A restart bit of one begins the curve again. Writing either
// register also restarts the curve. After a transfer is taken, the frame stack is walked
// one frame push, pop or phase advance per clock, but it stalls on a vertex while the
// output register is full and not taken. How long a vertex takes depends on how many
// frames close or open before it. A finished vertex waits in an output register while
// the next request is already taken. No clearing pass is needed after reset.
module sierpinski_curve_step_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [scsg_pkg::DATA_W-1:0] i_cfg_data,
    scsg_in_if.sink                     i_in,
    scsg_out_if.source                  o_out
);

    scsg_pkg::t_cmd  cmd;
    scsg_pkg::t_stat stat;

    scsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scsg_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_restart     (i_in.restart),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_step_x      (o_out.step_x),
        .o_step_y      (o_out.step_y),
        .o_is_relative (o_out.is_relative),
        .o_is_last     (o_out.is_last)
    );

endmodule
